// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL; clock clk_i, reset rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WAVRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WAVRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/wavrp_pkg.sv -----
`default_nettype none
package wavrp_pkg;

  localparam logic [31:0] MagicRiff   = 32'h4646_4952;
  localparam logic [31:0] MagicFmt    = 32'h2074_6D66;
  localparam logic [31:0] MagicData   = 32'h6174_6164;
  localparam logic [31:0] FmtBaseSize = 32'd16;

  // parse phases
  localparam logic [3:0] PhRiff     = 4'd0;
  localparam logic [3:0] PhHdrSkip  = 4'd1;
  localparam logic [3:0] PhFmtId    = 4'd2;
  localparam logic [3:0] PhFmtSize  = 4'd3;
  localparam logic [3:0] PhTag      = 4'd4;
  localparam logic [3:0] PhChan     = 4'd5;
  localparam logic [3:0] PhRate     = 4'd6;
  localparam logic [3:0] PhSkip6    = 4'd7;
  localparam logic [3:0] PhBits     = 4'd8;
  localparam logic [3:0] PhExt      = 4'd9;
  localparam logic [3:0] PhCkId     = 4'd10;
  localparam logic [3:0] PhCkSize   = 4'd11;
  localparam logic [3:0] PhCkSkip   = 4'd12;
  localparam logic [3:0] PhPayload  = 4'd13;
  localparam logic [3:0] PhIdle     = 4'd14;
  localparam logic [3:0] PhDataSize = 4'd15;

  // result kinds
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  // error codes
  localparam logic [2:0] ErrNotRiff   = 3'd0;
  localparam logic [2:0] ErrNoFmt     = 3'd1;
  localparam logic [2:0] ErrNotPcm    = 3'd2;
  localparam logic [2:0] ErrBadBits   = 3'd3;
  localparam logic [2:0] ErrBadChan   = 3'd4;
  localparam logic [2:0] ErrTruncated = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [1:0]  format;
    logic [1:0]  channels;
    logic [31:0] rate;
    logic [31:0] length;
    logic [2:0]  error;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/wav_riff_header_parser.sv -----
// Each result is registered, into the output register or, while the output is
// stalled, into the skid entry. One byte per cycle is taken while in_stall_o is
// low; each phase updates small counters, the field assembler and 32-bit compares.
// A two-entry output (register plus skid) takes one more result while the output
// is stalled; input stalls only while both entries are held.
// Reset (rst_ni low, asynchronous) returns the parser to the RIFF magic check.
`default_nettype none
`include "assert_macros.svh"
module wav_riff_header_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       format_code_o,
  output logic [1:0]       channel_count_o,
  output logic [31:0]      sample_rate_o,
  output logic [31:0]      data_length_o,
  output logic [2:0]       error_code_o,
  output logic             last_payload_o
);
  import wavrp_pkg::*;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] fmt_size_q, fmt_size_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  fmt_q, fmt_d;

  logic        out_valid_q, skid_valid_q;
  res_t        out_q, skid_q;

  logic        in_acc, out_take;
  logic        gather4, gather2, done, skip_done, err;
  logic        res_valid;
  logic [31:0] asm_new, rem_dec;
  logic [1:0]  base;
  res_t        res;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_comb begin
    gather4 = phase_q inside {PhRiff, PhFmtId, PhFmtSize, PhRate, PhCkId, PhCkSize,
                              PhDataSize};
    gather2 = phase_q inside {PhTag, PhChan, PhBits};
    asm_new = asm_q | ({24'b0, file_byte_i} << {cnt_q, 3'b000});
    done    = (gather4 && cnt_q == 2'd3) || (gather2 && cnt_q == 2'd1);
    rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : rem_q;
    skip_done = (rem_dec == 32'd0);
    base    = 2'd0;

    phase_d    = phase_q;
    cnt_d      = cnt_q;
    asm_d      = asm_q;
    fmt_size_d = fmt_size_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    rem_d      = rem_q;
    fmt_d      = fmt_q;
    res        = '0;
    res_valid  = 1'b0;
    err        = 1'b0;

    if (done) begin
      cnt_d = 2'd0;
      asm_d = 32'd0;
    end else if (gather4 || gather2) begin
      cnt_d = cnt_q + 2'd1;
      asm_d = asm_new;
    end

    case (phase_q)
      PhRiff: begin
        if (done) begin
          if (asm_new != MagicRiff) begin
            err = 1'b1; res.error = ErrNotRiff;
          end else begin
            rem_d = 32'd8; phase_d = PhHdrSkip;
          end
        end
      end
      PhHdrSkip: begin
        rem_d = rem_dec;
        if (skip_done) phase_d = PhFmtId;
      end
      PhFmtId: begin
        if (done) begin
          if (asm_new != MagicFmt) begin
            err = 1'b1; res.error = ErrNoFmt;
          end else begin
            phase_d = PhFmtSize;
          end
        end
      end
      PhFmtSize: begin
        if (done) begin
          fmt_size_d = asm_new; phase_d = PhTag;
        end
      end
      PhTag: begin
        if (done) begin
          if (asm_new != 32'd1) begin
            err = 1'b1; res.error = ErrNotPcm;
          end else begin
            phase_d = PhChan;
          end
        end
      end
      PhChan: begin
        if (done) begin
          chan_d = asm_new[15:0]; phase_d = PhRate;
        end
      end
      PhRate: begin
        if (done) begin
          rate_d = asm_new; rem_d = 32'd6; phase_d = PhSkip6;
        end
      end
      PhSkip6: begin
        rem_d = rem_dec;
        if (skip_done) phase_d = PhBits;
      end
      PhBits: begin
        if (done) begin
          // bit depth is checked ahead of the channel count
          if (!(asm_new inside {32'd8, 32'd16})) begin
            err = 1'b1; res.error = ErrBadBits;
          end else if (!(chan_q inside {16'd1, 16'd2})) begin
            err = 1'b1; res.error = ErrBadChan;
          end else begin
            base  = (asm_new == 32'd16) ? 2'd2 : 2'd0;
            fmt_d = base + ((chan_q == 16'd2) ? 2'd1 : 2'd0);
            if (fmt_size_q > FmtBaseSize) begin
              rem_d   = fmt_size_q - FmtBaseSize;
              phase_d = PhExt;
            end else begin
              phase_d = PhCkId;
            end
          end
        end
      end
      PhExt: begin
        rem_d = rem_dec;
        if (skip_done) phase_d = PhCkId;
      end
      PhCkId: begin
        if (done) phase_d = (asm_new == MagicData) ? PhDataSize : PhCkSize;
      end
      PhCkSize: begin
        if (done) begin
          rem_d   = asm_new;
          phase_d = (asm_new == 32'd0) ? PhCkId : PhCkSkip;
        end
      end
      PhCkSkip: begin
        rem_d = rem_dec;
        if (skip_done) phase_d = PhCkId;
      end
      PhDataSize: begin
        if (done) begin
          res_valid    = 1'b1;
          res.kind     = KindHeader;
          res.format   = fmt_q;
          res.channels = chan_q[1:0];
          res.rate     = rate_q;
          res.length   = asm_new;
          rem_d        = asm_new;
          phase_d      = (asm_new == 32'd0) ? PhIdle : PhPayload;
        end
      end
      PhPayload: begin
        res_valid   = 1'b1;
        res.kind    = KindPayload;
        res.payload = file_byte_i;
        rem_d       = rem_dec;
        if (skip_done) begin
          res.last = 1'b1;
          phase_d  = PhIdle;
        end
      end
      default: ;
    endcase

    if (err) begin
      res_valid = 1'b1;
      res.kind  = KindError;
      phase_d   = PhIdle;
    end

    if (end_of_stream_i) begin
      // early end overrides a header or payload beat of this byte unless the parse ends on it
      if (!err && phase_d != PhIdle) begin
        res_valid = 1'b1;
        res       = '0;
        res.kind  = KindError;
        res.error = ErrTruncated;
      end
      phase_d    = PhRiff;
      cnt_d      = 2'd0;
      asm_d      = 32'd0;
      fmt_size_d = 32'd0;
      chan_d     = 16'd0;
      rate_d     = 32'd0;
      rem_d      = 32'd0;
      fmt_d      = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhRiff;
      cnt_q      <= 2'd0;
      asm_q      <= 32'd0;
      fmt_size_q <= 32'd0;
      chan_q     <= 16'd0;
      rate_q     <= 32'd0;
      rem_q      <= 32'd0;
      fmt_q      <= 2'd0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      asm_q      <= asm_d;
      fmt_size_q <= fmt_size_d;
      chan_q     <= chan_d;
      rate_q     <= rate_d;
      rem_q      <= rem_d;
      fmt_q      <= fmt_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_acc && res_valid) begin
        if (out_valid_q && !out_take) skid_valid_q <= 1'b1;
        else out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_acc && res_valid) begin
      if (out_valid_q && !out_take) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign payload_byte_o  = out_q.payload;
  assign format_code_o   = out_q.format;
  assign channel_count_o = out_q.channels;
  assign sample_rate_o   = out_q.rate;
  assign data_length_o   = out_q.length;
  assign error_code_o    = out_q.error;
  assign last_payload_o  = out_q.last;

  `WAVRP_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry without output")
  `WAVRP_ASSERT_IMP(a_payload_has_rem, phase_q == PhPayload, rem_q != 32'd0,
                    "payload phase with nothing left")
  `WAVRP_ASSERT_NXT(a_error_stops, in_acc && res_valid && res.kind == KindError,
                    phase_q == PhIdle || phase_q == PhRiff, "parser runs on after error")
  `WAVRP_ASSERT_IMP(a_last_only_payload, out_valid_q && out_q.last,
                    out_q.kind == KindPayload, "last flag on non-payload beat")

endmodule
`default_nettype wire

// ----- tb/wav_riff_header_parser_test.sv -----
`timescale 1ns / 1ps
module wav_riff_header_parser_test;
  import wavrp_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        eos;
    int unsigned gap;
    bit          drain;
  } byte_item_t;

  typedef struct {
    logic [31:0] riff;
    logic [31:0] fmt_id;
    logic [31:0] fmt_len;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    int          junk;
    logic [31:0] junk_len;
    logic [31:0] data_len;
    int          data_have;
    int          cut;
    int          tail;
    bit          drain;
  } wav_spec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  file_byte_i = 8'd0;
  logic        end_of_stream_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  format_code_o;
  logic [1:0]  channel_count_o;
  logic [31:0] sample_rate_o;
  logic [31:0] data_length_o;
  logic [2:0]  error_code_o;
  logic        last_payload_o;

  byte_item_t  byte_queue[$];
  res_t        due_results[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_count = 0;
  int unsigned tx_max = 6;
  int unsigned rx_max = 6;
  int unsigned gap_done = 0;
  int unsigned hold_left = 0;
  bit          byte_taken = 1'b0;
  bit          result_taken = 1'b0;

  // parser state mirrored by the predictor
  logic [3:0]  parse_at;
  logic [31:0] field_idx;
  logic [31:0] field_acc;
  logic [31:0] fmt_bytes;
  logic [15:0] chan_word;
  logic [31:0] rate_word;
  logic [31:0] skip_left;
  logic [1:0]  format_bits;

  always #10 clk_i = ~clk_i;

  wav_riff_header_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .file_byte_i     (file_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .format_code_o   (format_code_o),
    .channel_count_o (channel_count_o),
    .sample_rate_o   (sample_rate_o),
    .data_length_o   (data_length_o),
    .error_code_o    (error_code_o),
    .last_payload_o  (last_payload_o)
  );

  function automatic void clear_parser();
    parse_at    = PhRiff;
    field_idx   = '0;
    field_acc   = '0;
    fmt_bytes   = '0;
    chan_word   = '0;
    rate_word   = '0;
    skip_left   = '0;
    format_bits = '0;
  endfunction

  function automatic bit skip_done();
    if (skip_left != 0) skip_left--;
    return skip_left == 0;
  endfunction

  function automatic res_t error_beat(input logic [2:0] code);
    res_t r;
    r = '0;
    r.kind = KindError;
    r.error = code;
    parse_at = PhIdle;
    return r;
  endfunction

  // Advances the mirrored parser by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic eos, output res_t r);
    int unsigned field_len;
    logic [31:0] word;
    bit          complete;
    bit          failed;
    bit          emitted;
    r = '0;
    word = '0;
    complete = 1'b0;
    failed = 1'b0;
    emitted = 1'b0;
    case (parse_at)
      PhRiff, PhFmtId, PhFmtSize, PhRate, PhCkId, PhCkSize, PhDataSize: field_len = 4;
      PhTag, PhChan, PhBits: field_len = 2;
      default: field_len = 0;
    endcase
    if (field_len != 0) begin
      field_acc |= {24'd0, b} << (8 * field_idx[1:0]);
      field_idx++;
      if (field_idx >= field_len) begin
        field_idx = '0;
        complete = 1'b1;
        word = field_acc;
        field_acc = '0;
      end
    end
    case (parse_at)
      PhRiff: if (complete) begin
        if (word != MagicRiff) begin
          r = error_beat(ErrNotRiff);
          failed = 1'b1;
        end else begin
          skip_left = 32'd8;
          parse_at = PhHdrSkip;
        end
      end
      PhHdrSkip: if (skip_done()) parse_at = PhFmtId;
      PhFmtId: if (complete) begin
        if (word != MagicFmt) begin
          r = error_beat(ErrNoFmt);
          failed = 1'b1;
        end else begin
          parse_at = PhFmtSize;
        end
      end
      PhFmtSize: if (complete) begin
        fmt_bytes = word;
        parse_at = PhTag;
      end
      PhTag: if (complete) begin
        if (word != 32'd1) begin
          r = error_beat(ErrNotPcm);
          failed = 1'b1;
        end else begin
          parse_at = PhChan;
        end
      end
      PhChan: if (complete) begin
        chan_word = word[15:0];
        parse_at = PhRate;
      end
      PhRate: if (complete) begin
        rate_word = word;
        skip_left = 32'd6;
        parse_at = PhSkip6;
      end
      PhSkip6: if (skip_done()) parse_at = PhBits;
      PhBits: if (complete) begin
        // bit depth is judged before the channel count
        if (word != 32'd8 && word != 32'd16) begin
          r = error_beat(ErrBadBits);
          failed = 1'b1;
        end else if (chan_word != 16'd1 && chan_word != 16'd2) begin
          r = error_beat(ErrBadChan);
          failed = 1'b1;
        end else begin
          format_bits = {word == 32'd16, chan_word == 16'd2};
          if (fmt_bytes > FmtBaseSize) begin
            skip_left = fmt_bytes - FmtBaseSize;
            parse_at = PhExt;
          end else begin
            parse_at = PhCkId;
          end
        end
      end
      PhExt: if (skip_done()) parse_at = PhCkId;
      PhCkId: if (complete) parse_at = (word == MagicData) ? PhDataSize : PhCkSize;
      PhCkSize: if (complete) begin
        skip_left = word;
        parse_at = (word == 0) ? PhCkId : PhCkSkip;
      end
      PhCkSkip: if (skip_done()) parse_at = PhCkId;
      PhDataSize: if (complete) begin
        r.kind = KindHeader;
        r.format = format_bits;
        r.channels = chan_word[1:0];
        r.rate = rate_word;
        r.length = word;
        emitted = 1'b1;
        skip_left = word;
        parse_at = (word == 0) ? PhIdle : PhPayload;
      end
      PhPayload: begin
        r.kind = KindPayload;
        r.payload = b;
        emitted = 1'b1;
        if (skip_done()) begin
          r.last = 1'b1;
          parse_at = PhIdle;
        end
      end
      default: ;
    endcase
    if (eos) begin
      // early end overrides header/payload unless the parse ends there, not an error of this very byte
      if (!failed && parse_at != PhIdle) begin
        r = error_beat(ErrTruncated);
        emitted = 1'b1;
      end
      clear_parser();
    end
    return emitted || failed;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // input side: hold while stalled, otherwise optional drain, gap, then next beat
  always @(negedge clk_i) begin : drive_bytes
    byte_item_t head;
    if (rst_ni && !(in_valid_i && !byte_taken)) begin
      if (byte_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else begin
        head = byte_queue[0];
        if (head.drain && due_results.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_done < head.gap) begin
          gap_done++;
          in_valid_i <= 1'b0;
        end else begin
          void'(byte_queue.pop_front());
          gap_done = 0;
          in_valid_i <= 1'b1;
          file_byte_i <= head.data;
          end_of_stream_i <= head.eos;
        end
      end
    end
  end

  // output side: a fresh stall length is drawn after each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) hold_left = $urandom_range(0, rx_max);
      out_stall_i <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  always @(posedge clk_i) begin : watch_beats
    res_t predicted;
    res_t got;
    res_t want;
    if (rst_ni) begin
      byte_taken <= in_valid_i && !in_stall_o;
      result_taken <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        if (parse_byte(file_byte_i, end_of_stream_i, predicted))
          due_results.push_back(predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{kind: result_kind_o, payload: payload_byte_o, format: format_code_o,
                channels: channel_count_o, rate: sample_rate_o, length: data_length_o,
                error: error_code_o, last: last_payload_o};
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result, kind", 32'(got.kind), '0);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind)
            note_mismatch("result_kind", 32'(got.kind), 32'(want.kind));
          if (got.payload !== want.payload)
            note_mismatch("payload_byte", 32'(got.payload), 32'(want.payload));
          if (got.format !== want.format)
            note_mismatch("format_code", 32'(got.format), 32'(want.format));
          if (got.channels !== want.channels)
            note_mismatch("channel_count", 32'(got.channels), 32'(want.channels));
          if (got.rate !== want.rate) note_mismatch("sample_rate", got.rate, want.rate);
          if (got.length !== want.length)
            note_mismatch("data_length", got.length, want.length);
          if (got.error !== want.error)
            note_mismatch("error_code", 32'(got.error), 32'(want.error));
          if (got.last !== want.last)
            note_mismatch("last_payload", 32'(got.last), 32'(want.last));
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic eos, input bit drain);
    byte_item_t it;
    it.data = data;
    it.eos = eos;
    it.gap = $urandom_range(0, tx_max);
    it.drain = drain;
    byte_queue.push_back(it);
    bytes_queued++;
  endtask

  function automatic void put_le(ref logic [7:0] img[$], input logic [31:0] w, input int n);
    for (int k = 0; k < n; k++) img.push_back(w[8*k +: 8]);
  endfunction

  function automatic wav_spec_t good_spec();
    wav_spec_t s;
    s.riff = MagicRiff;
    s.fmt_id = MagicFmt;
    s.fmt_len = FmtBaseSize;
    s.tag = 16'd1;
    s.chans = 16'd1;
    s.bits = 16'd8;
    s.rate = '0;
    s.junk = 0;
    s.junk_len = '0;
    s.data_len = '0;
    s.data_have = 0;
    s.cut = 0;
    s.tail = 0;
    s.drain = 1'b0;
    return s;
  endfunction

  // Builds the file image, cuts it if asked, appends trailing bytes, marks eos.
  task automatic send_wav(input wav_spec_t s);
    logic [7:0]  img[$];
    logic [31:0] id;
    int          total;
    put_le(img, s.riff, 4);
    put_le(img, $urandom, 4);
    put_le(img, $urandom, 4);
    put_le(img, s.fmt_id, 4);
    put_le(img, s.fmt_len, 4);
    put_le(img, 32'(s.tag), 2);
    put_le(img, 32'(s.chans), 2);
    put_le(img, s.rate, 4);
    put_le(img, $urandom, 4);
    put_le(img, $urandom, 2);
    put_le(img, 32'(s.bits), 2);
    for (int i = 16; i < s.fmt_len && i < 24; i++) img.push_back(8'($urandom));
    for (int c = 0; c < s.junk; c++) begin
      id = $urandom;
      if (id == MagicData) id[0] = ~id[0];
      put_le(img, id, 4);
      put_le(img, s.junk_len, 4);
      for (int k = 0; k < s.junk_len && k < 8; k++) img.push_back(8'($urandom));
    end
    put_le(img, MagicData, 4);
    put_le(img, s.data_len, 4);
    for (int k = 0; k < s.data_have; k++) img.push_back(8'($urandom));
    total = (s.cut > 0 && s.cut < img.size()) ? s.cut : img.size();
    for (int i = 0; i < total; i++)
      push_byte(img[i], (i == total - 1) && (s.tail == 0), (i == 0) && s.drain);
    for (int t = 0; t < s.tail; t++) push_byte(8'($urandom), t == s.tail - 1, 1'b0);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0), 1'b0);
  endtask

  initial begin : stimulus
    wav_spec_t s;
    int unsigned files;
    int unsigned pick;
    int unsigned waited;
    clear_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: formats, extremes, every error and the early-end cases
    s = good_spec(); send_wav(s);                            // empty data, rate 0
    s = good_spec(); s.chans = 2; s.bits = 16; s.rate = '1;
    s.data_len = 3; s.data_have = 3; send_wav(s);            // eos on last payload
    s = good_spec(); s.bits = 16; s.data_len = 2; s.data_have = 2; s.tail = 2;
    send_wav(s);                                             // bytes after payload ignored
    s = good_spec(); s.chans = 2; s.fmt_len = 0; s.junk = 2; s.junk_len = 3;
    s.data_len = 1; s.data_have = 1; send_wav(s);            // short fmt, odd chunks
    s = good_spec(); s.fmt_len = 18; s.junk = 1; s.data_len = 2; s.data_have = 2;
    s.tail = 1; send_wav(s);                                 // fmt extension, empty chunk
    s = good_spec(); s.riff = 32'h4646_4953; s.tail = 3; s.drain = 1'b1; send_wav(s);
    s = good_spec(); s.riff = '0; s.cut = 4; send_wav(s);    // bad magic on the eos byte
    s = good_spec(); s.fmt_id = MagicData; s.tail = 2; send_wav(s);
    s = good_spec(); s.tag = 16'hFFFF; s.tail = 1; send_wav(s);
    s = good_spec(); s.tag = 16'd0; s.cut = 22; send_wav(s); // tag error beats truncation
    s = good_spec(); s.bits = 16'd24; s.chans = 16'd3; s.tail = 1; send_wav(s);
    s = good_spec(); s.chans = 16'd0; s.tail = 2; send_wav(s);
    s = good_spec(); s.chans = 16'hFFFF; s.bits = 16'd16; send_wav(s);
    s = good_spec(); s.data_len = 4; s.data_have = 4; s.cut = 20; send_wav(s);
    s = good_spec(); s.data_len = 5; s.data_have = 5; s.cut = 44; send_wav(s);
    s = good_spec(); s.cut = 44; s.tail = 0; send_wav(s);    // empty data on the eos byte
    s = good_spec(); s.data_len = '1; s.data_have = 3; send_wav(s);
    s = good_spec(); s.junk = 1; s.junk_len = '1; send_wav(s);
    s = good_spec(); s.fmt_len = '1; send_wav(s);
    send_noise(1);

    // random files, mostly well formed, with noise and broken ones mixed in
    files = 0;
    while (bytes_queued < 1100) begin
      while (byte_queue.size() > 8) @(posedge clk_i);
      tx_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
      rx_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
      files++;
      if ($urandom_range(0, 9) < 2) begin
        send_noise($urandom_range(1, 10));
      end else begin
        s = good_spec();
        s.chans = 16'($urandom_range(1, 2));
        s.bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
        s.rate = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 4) s.riff = $urandom;
        else if (pick < 8) s.fmt_id = $urandom;
        else if (pick < 12) s.tag = 16'($urandom);
        else if (pick < 17) s.bits = $urandom_range(0, 1) ? 16'(24) : 16'($urandom);
        else if (pick < 22) s.chans = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick >= 8) s.fmt_len = $urandom_range(17, 24);
        else if (pick >= 6) s.fmt_len = $urandom_range(0, 15);
        s.junk = $urandom_range(0, 2);
        s.junk_len = $urandom_range(0, 5);
        if ($urandom_range(0, 9) == 0) begin
          s.data_len = $urandom;
          s.data_have = $urandom_range(0, 12);
        end else begin
          s.data_len = $urandom_range(0, 12);
          s.data_have = s.data_len;
        end
        if ($urandom_range(0, 7) == 0) s.cut = $urandom_range(1, 60);
        if ($urandom_range(0, 1) == 0) s.tail = $urandom_range(1, 3);
        s.drain = (files % 12 == 0);
        send_wav(s);
      end
    end

    while (byte_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    waited = 0;
    while (due_results.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (due_results.size() != 0) note_mismatch("results never seen", due_results.size(), 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/wavrp_pkg.sv
hdl/wav_riff_header_parser.sv
tb/wav_riff_header_parser_test.sv
